// ----- src/cppm_pkg.sv -----
// ----------------------------------------------------------------------------
// cppm_pkg: shared types and constants for the close peak pair merge
// Field widths, result beat layout, peak count codes and merge helpers.
// ----------------------------------------------------------------------------
package cppm_pkg;

    localparam int MZ_BITS              = 28;
    localparam int INTENSITY_BITS       = 32;
    localparam int MAX_RESULTS          = 3;
    localparam int PUSH_CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH          = 8;
    localparam int QPTR_W               = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W               = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MZ_BITS-1:0] MERGE_DISTANCE_RESET = MZ_BITS'(7864);

    // peaks of the current spectrum seen so far, saturating at three
    typedef enum logic [3:0] {
        SEEN_NONE = 4'b0001,
        SEEN_ONE  = 4'b0010,
        SEEN_TWO  = 4'b0100,
        SEEN_MANY = 4'b1000
    } t_seen;

    typedef struct packed {
        logic [MZ_BITS-1:0]        mz;
        logic [INTENSITY_BITS-1:0] intensity;
        logic                      merged;
        logic                      last;
    } t_result;

    // result beats produced by one accepted peak
    typedef struct packed {
        logic [PUSH_CNT_W-1:0]         count;
        t_result [MAX_RESULTS-1:0]     beat;
    } t_push;

    // spacing of two m/z values below the merge distance
    function automatic logic is_close(input logic [MZ_BITS-1:0] a,
                                      input logic [MZ_BITS-1:0] b,
                                      input logic [MZ_BITS-1:0] limit);
        logic [MZ_BITS-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        return diff < limit;
    endfunction

    // merged peak of an earlier peak a and a later peak b
    function automatic t_result join_peaks(input logic [MZ_BITS-1:0]        a_mz,
                                           input logic [INTENSITY_BITS-1:0] a_int,
                                           input logic [MZ_BITS-1:0]        b_mz,
                                           input logic [INTENSITY_BITS-1:0] b_int,
                                           input logic                      last);
        t_result                 res;
        logic [INTENSITY_BITS:0] sum;
        sum           = {1'b0, a_int} + {1'b0, b_int};
        res.intensity = sum[INTENSITY_BITS] ? '1 : sum[INTENSITY_BITS-1:0];
        res.mz        = (b_int > a_int) ? b_mz : a_mz;
        res.merged    = 1'b1;
        res.last      = last;
        return res;
    endfunction

    // peak passed on unchanged
    function automatic t_result plain_peak(input logic [MZ_BITS-1:0]        mz,
                                           input logic [INTENSITY_BITS-1:0] inten,
                                           input logic                      last);
        t_result res;
        res.mz        = mz;
        res.intensity = inten;
        res.merged    = 1'b0;
        res.last      = last;
        return res;
    endfunction

endpackage

// ----- src/cppm_if.sv -----
// ----------------------------------------------------------------------------
// cppm_if: valid/ready channels of the close peak pair merge
// Peak input channel and merged result channel.
// ----------------------------------------------------------------------------
interface cppm_peak_if import cppm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MZ_BITS-1:0]        peak_mz;
    logic [INTENSITY_BITS-1:0] peak_intensity;
    logic                      spectrum_end;

    modport source (output valid, peak_mz, peak_intensity, spectrum_end, input ready);
    modport sink   (input valid, peak_mz, peak_intensity, spectrum_end, output ready);
endinterface

interface cppm_result_if import cppm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MZ_BITS-1:0]        out_mz;
    logic [INTENSITY_BITS-1:0] out_intensity;
    logic                      was_merged;
    logic                      out_last;

    modport source (output valid, out_mz, out_intensity, was_merged, out_last, input ready);
    modport sink   (input valid, out_mz, out_intensity, was_merged, out_last, output ready);
endinterface

// ----- src/cppm_pair_core.sv -----
// ----------------------------------------------------------------------------
// cppm_pair_core: greedy pairing of neighbouring peaks
// Holds the unpaired candidate peaks and produces up to three result beats
// for each accepted peak in a single pass.
// ----------------------------------------------------------------------------
module cppm_pair_core import cppm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [MZ_BITS-1:0]        i_mz,
    input  logic [INTENSITY_BITS-1:0] i_intensity,
    input  logic                      i_end,
    input  logic [MZ_BITS-1:0]        i_merge_distance,
    output t_push                     o_push
);

    t_seen                     r_seen, n_seen;
    logic                      r_held, n_held;
    logic [MZ_BITS-1:0]        r_first_mz, n_first_mz;
    logic [INTENSITY_BITS-1:0] r_first_int, n_first_int;
    logic [MZ_BITS-1:0]        r_second_mz, n_second_mz;
    logic [INTENSITY_BITS-1:0] r_second_int, n_second_int;

    logic                      close_12, close_1x, close_2x;
    logic [MZ_BITS-1:0]        cur_mz;
    logic [INTENSITY_BITS-1:0] cur_int;
    logic                      cur_held, cur_close;
    logic [PUSH_CNT_W-1:0]     cnt;
    t_result [MAX_RESULTS-1:0] res;

    // spacing checks, all in parallel
    assign close_12 = is_close(r_first_mz, r_second_mz, i_merge_distance);
    assign close_1x = is_close(r_first_mz, i_mz, i_merge_distance);
    assign close_2x = is_close(r_second_mz, i_mz, i_merge_distance);

    // next state and result beats for the peak on the input
    always_comb begin
        n_seen       = r_seen;
        n_held       = r_held;
        n_first_mz   = r_first_mz;
        n_first_int  = r_first_int;
        n_second_mz  = r_second_mz;
        n_second_int = r_second_int;
        cnt          = '0;
        res          = '0;
        cur_mz       = r_first_mz;
        cur_int      = r_first_int;
        cur_held     = r_held;
        cur_close    = close_1x;

        case (r_seen)
            SEEN_NONE: begin
                if (i_end) begin
                    res[cnt] = plain_peak(i_mz, i_intensity, 1'b1);
                    cnt      = cnt + 1'b1;
                end else begin
                    n_first_mz  = i_mz;
                    n_first_int = i_intensity;
                    n_held      = 1'b1;
                    n_seen      = SEEN_ONE;
                end
            end
            SEEN_ONE: begin
                if (i_end) begin
                    res[cnt] = plain_peak(r_first_mz, r_first_int, 1'b0);
                    cnt      = cnt + 1'b1;
                    res[cnt] = plain_peak(i_mz, i_intensity, 1'b1);
                    cnt      = cnt + 1'b1;
                end else begin
                    n_second_mz  = i_mz;
                    n_second_int = i_intensity;
                    n_seen       = SEEN_TWO;
                end
            end
            SEEN_TWO, SEEN_MANY: begin
                // third peak: pair the first two held peaks
                if (r_seen == SEEN_TWO) begin
                    if (close_12) begin
                        res[cnt] = join_peaks(r_first_mz, r_first_int,
                                              r_second_mz, r_second_int, 1'b0);
                        cnt      = cnt + 1'b1;
                        cur_held = 1'b0;
                    end else begin
                        res[cnt]  = plain_peak(r_first_mz, r_first_int, 1'b0);
                        cnt       = cnt + 1'b1;
                        cur_mz    = r_second_mz;
                        cur_int   = r_second_int;
                        cur_held  = 1'b1;
                        cur_close = close_2x;
                    end
                end
                // candidate against the new peak
                if (cur_held && cur_close) begin
                    res[cnt]    = join_peaks(cur_mz, cur_int, i_mz, i_intensity, i_end);
                    cnt         = cnt + 1'b1;
                    n_first_mz  = '0;
                    n_first_int = '0;
                    n_held      = 1'b0;
                end else begin
                    if (cur_held) begin
                        res[cnt] = plain_peak(cur_mz, cur_int, 1'b0);
                        cnt      = cnt + 1'b1;
                    end
                    n_first_mz  = i_mz;
                    n_first_int = i_intensity;
                    n_held      = 1'b1;
                    if (i_end) begin
                        res[cnt] = plain_peak(i_mz, i_intensity, 1'b1);
                        cnt      = cnt + 1'b1;
                    end
                end
                n_seen = SEEN_MANY;
            end
            default: begin
                n_seen = SEEN_NONE;
            end
        endcase

        // end of spectrum returns to a fresh start
        if (i_end) begin
            n_seen      = SEEN_NONE;
            n_held      = 1'b0;
            n_first_mz  = '0;
            n_first_int = '0;
        end
    end

    assign o_push.count = i_accept ? cnt : '0;
    assign o_push.beat  = res;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= SEEN_NONE;
            r_held <= 1'b0;
        end else if (i_accept) begin
            r_seen <= n_seen;
            r_held <= n_held;
        end
    end

    // held peaks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_mz   <= '0;
            r_first_int  <= '0;
            r_second_mz  <= '0;
            r_second_int <= '0;
        end else if (i_accept) begin
            r_first_mz   <= n_first_mz;
            r_first_int  <= n_first_int;
            r_second_mz  <= n_second_mz;
            r_second_int <= n_second_int;
        end
    end

endmodule

// ----- src/cppm_out_queue.sv -----
// ----------------------------------------------------------------------------
// cppm_out_queue: result queue with multi-beat write
// Takes up to three result beats per cycle and hands them out one per cycle
// while the output is ready; reports room for a full burst to the input side.
// ----------------------------------------------------------------------------
module cppm_out_queue import cppm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_push                i_push,
    output logic                 o_room,
    cppm_result_if.source        o_result
);

    localparam logic [QCNT_W-1:0] ROOM_LIMIT = QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);

    t_result            r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               pop;
    t_result            head;

    assign pop    = o_result.valid && o_result.ready;
    assign o_room = (r_count <= ROOM_LIMIT);

    // head beat
    assign head                   = r_q[r_rd_ptr];
    assign o_result.valid         = (r_count != '0);
    assign o_result.out_mz        = head.mz;
    assign o_result.out_intensity = head.intensity;
    assign o_result.was_merged    = head.merged;
    assign o_result.out_last      = head.last;

    // pointer and fill arithmetic
    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
        n_count  = r_count + QCNT_W'(i_push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // burst write of the new beats
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (PUSH_CNT_W'(k) < i_push.count) begin
                r_q[r_wr_ptr + QPTR_W'(k)] <= i_push.beat[k];
            end
        end
    end

endmodule

// ----- src/close_peak_pair_merge.sv -----
// ----------------------------------------------------------------------------
// close_peak_pair_merge: one-pass merge of close neighbouring peaks
// Pairs each peak with the unpaired peak before it and emits merged or
// plain peaks through a short result queue.
//
//   channel     dir  handshake      beat contents
//   i_peak      in   valid/ready    peak_mz, peak_intensity, spectrum_end
//   o_result    out  valid/ready    out_mz, out_intensity, was_merged, out_last
//   i_cfg_*     in   write enable   merge_distance
//
// One peak is taken every cycle while the queue has room; its zero to
// three result beats are written to an eight-entry queue in the same cycle
// and leave one a cycle while the output is ready. Input ready drops only
// while the queue lacks room for a three-beat burst; results are registered.
// Synchronous active-low reset empties the queue, clears the held peaks and
// restores the merge distance to 7864.
// ----------------------------------------------------------------------------
module close_peak_pair_merge import cppm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [MZ_BITS-1:0] i_cfg_wdata,
    cppm_peak_if.sink          i_peak,
    cppm_result_if.source      o_result
);

    logic [MZ_BITS-1:0] r_merge_distance;
    logic               accept;
    logic               room;
    t_push              push;

    // merge distance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_distance <= MERGE_DISTANCE_RESET;
        end else if (i_cfg_we) begin
            r_merge_distance <= i_cfg_wdata;
        end
    end

    assign i_peak.ready = room;
    assign accept       = i_peak.valid && room;

    // pairing logic
    cppm_pair_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_mz             (i_peak.peak_mz),
        .i_intensity      (i_peak.peak_intensity),
        .i_end            (i_peak.spectrum_end),
        .i_merge_distance (r_merge_distance),
        .o_push           (push)
    );

    // result queue
    cppm_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_result (o_result)
    );

endmodule
